>>> rtl/dgsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgsp_pkg
// Shared constants, controller state type and the command/status structs
// that join the shortest-path controller to its datapath.
// ----------------------------------------------------------------------------
package dgsp_pkg;

    // Defaults for the top-level parameters
    localparam int VERTICES_DEF    = 8;
    localparam int WEIGHT_BITS_DEF = 16;

    // Fixed field widths of the ports
    localparam int VTX_BITS    = 3;
    localparam int WIN_BITS    = 16;
    localparam int DIST_BITS   = 24;

    // Input kind codes
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_RUN  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,   // sweep weight matrix to zero after reset
        ST_IDLE,
        ST_SCAN,    // issue distance reads for the min search
        ST_SDRAIN,  // compare the last scanned vertex
        ST_MARK,    // mark the picked vertex visited
        ST_RELAX,   // issue weight/distance reads for relaxation
        ST_RDRAIN,  // relax the last vertex, close the round
        ST_EMIT,    // issue result reads
        ST_EDRAIN   // last result on the ports
    } t_state;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic init;
        logic scan;
        logic mark;
        logic relax;
        logic round_end;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic idx_last;
        logic round_last;
        logic u_reached;
    } t_status;

endpackage : dgsp_pkg
`default_nettype wire

>>> rtl/dgsp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgsp_ctrl
// Sequencer: clear pass, loads, the scan / mark / relax rounds of a run and result output.
// ----------------------------------------------------------------------------
module dgsp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic             i_kind,
    input  wire dgsp_pkg::t_status i_status,
    output dgsp_pkg::t_cmd         o_cmd,
    output logic                   busy
);

    dgsp_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dgsp_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dgsp_pkg::ST_CLEAR: begin
                if (i_status.clear_last) n_state = dgsp_pkg::ST_IDLE;
            end
            dgsp_pkg::ST_IDLE: begin
                if (start && i_kind == dgsp_pkg::KIND_RUN) n_state = dgsp_pkg::ST_SCAN;
            end
            dgsp_pkg::ST_SCAN: begin
                if (i_status.idx_last) n_state = dgsp_pkg::ST_SDRAIN;
            end
            dgsp_pkg::ST_SDRAIN: begin
                n_state = dgsp_pkg::ST_MARK;
            end
            dgsp_pkg::ST_MARK: begin
                if (i_status.u_reached)       n_state = dgsp_pkg::ST_RELAX;
                else if (i_status.round_last) n_state = dgsp_pkg::ST_EMIT;
                else                          n_state = dgsp_pkg::ST_SCAN;
            end
            dgsp_pkg::ST_RELAX: begin
                if (i_status.idx_last) n_state = dgsp_pkg::ST_RDRAIN;
            end
            dgsp_pkg::ST_RDRAIN: begin
                n_state = i_status.round_last ? dgsp_pkg::ST_EMIT : dgsp_pkg::ST_SCAN;
            end
            dgsp_pkg::ST_EMIT: begin
                if (i_status.idx_last) n_state = dgsp_pkg::ST_EDRAIN;
            end
            dgsp_pkg::ST_EDRAIN: begin
                n_state = dgsp_pkg::ST_IDLE;
            end
            default: begin
                n_state = dgsp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b1;
        unique case (r_state)
            dgsp_pkg::ST_CLEAR:  o_cmd.clear_step = 1'b1;
            dgsp_pkg::ST_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start && i_kind == dgsp_pkg::KIND_LOAD;
                o_cmd.init = start && i_kind == dgsp_pkg::KIND_RUN;
            end
            dgsp_pkg::ST_SCAN:   o_cmd.scan = 1'b1;
            dgsp_pkg::ST_SDRAIN: o_cmd = '0;
            dgsp_pkg::ST_MARK: begin
                o_cmd.mark      = 1'b1;
                o_cmd.round_end = !i_status.u_reached;
            end
            dgsp_pkg::ST_RELAX:  o_cmd.relax = 1'b1;
            dgsp_pkg::ST_RDRAIN: o_cmd.round_end = 1'b1;
            dgsp_pkg::ST_EMIT:   o_cmd.emit = 1'b1;
            dgsp_pkg::ST_EDRAIN: o_cmd = '0;
            default:             o_cmd = '0;
        endcase
    end

endmodule : dgsp_ctrl
`default_nettype wire

>>> rtl/dgsp_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgsp_datapath
// Weight matrix, per-vertex distance/predecessor memories, visit flags,
// min-search compare and relaxation adder, result formatting.
// ----------------------------------------------------------------------------
module dgsp_datapath #(
    parameter int VERTICES    = dgsp_pkg::VERTICES_DEF,
    parameter int WEIGHT_BITS = dgsp_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire dgsp_pkg::t_cmd                   i_cmd,
    input  wire logic [dgsp_pkg::VTX_BITS-1:0]    i_from_vertex,
    input  wire logic [dgsp_pkg::VTX_BITS-1:0]    i_to_vertex,
    input  wire logic [dgsp_pkg::WIN_BITS-1:0]    i_weight,
    input  wire logic [dgsp_pkg::VTX_BITS-1:0]    i_source_vertex,
    output dgsp_pkg::t_status                      o_status,
    output logic                                  o_result_valid,
    output logic [dgsp_pkg::VTX_BITS-1:0]          o_vertex,
    output logic [dgsp_pkg::DIST_BITS-1:0]         o_path_length,
    output logic                                  o_reachable,
    output logic [dgsp_pkg::VTX_BITS-1:0]          o_predecessor,
    output logic                                  o_has_predecessor,
    output logic                                  o_last
);

    localparam int VW = $clog2(VERTICES);
    localparam int NN = VERTICES * VERTICES;
    localparam int AW = $clog2(NN);
    localparam int DB = dgsp_pkg::DIST_BITS;

    // Memories
    logic [WEIGHT_BITS-1:0] wmem     [NN];
    logic [DB-1:0]          dist_mem [VERTICES];
    logic [VW-1:0]          prev_mem [VERTICES];

    // Counters and pipeline
    logic [AW-1:0]          r_caddr;
    logic [VW-1:0]          r_idx;
    logic [VW-1:0]          r_round;
    logic [VW-1:0]          r_jd;
    logic                   r_scan_v, r_relax_v, r_emit_v;

    // Read data
    logic [WEIGHT_BITS-1:0] r_w_q;
    logic [DB-1:0]          r_dist_q;
    logic [VW-1:0]          r_prev_q;

    // Per-vertex flags
    logic [VERTICES-1:0]    r_done, r_reached, r_pv;

    // Min search
    logic                   r_have;
    logic [DB:0]            r_best_key;
    logic [VW-1:0]          r_best_u;

    // Input decode
    logic [31:0]            src_ext, row_ext, col_ext, w_ext;
    logic                   src_ok, load_ok;
    logic [VW-1:0]          src_idx;
    logic [VERTICES-1:0]    src_onehot;
    logic [31:0]            laddr_ext, raddr_ext;
    logic [AW-1:0]          laddr, raddr;
    logic [WEIGHT_BITS-1:0] w_in;

    assign src_ext    = 32'(i_source_vertex);
    assign row_ext    = 32'(i_from_vertex);
    assign col_ext    = 32'(i_to_vertex);
    assign w_ext      = 32'(i_weight);
    assign src_ok     = src_ext < 32'(VERTICES);
    assign load_ok    = (row_ext < 32'(VERTICES)) && (col_ext < 32'(VERTICES));
    assign src_idx    = src_ext[VW-1:0];
    assign src_onehot = src_ok ? (VERTICES'(1) << src_idx) : '0;
    assign w_in       = w_ext[WEIGHT_BITS-1:0];
    assign laddr_ext  = row_ext * 32'(VERTICES) + col_ext;
    assign laddr      = laddr_ext[AW-1:0];
    assign raddr_ext  = 32'(r_best_u) * 32'(VERTICES) + 32'(r_idx);
    assign raddr      = raddr_ext[AW-1:0];

    // Scan compare: unreached vertices rank above every reached distance
    logic [DB:0]            key;
    logic                   take;
    assign key  = r_reached[r_jd] ? {1'b0, r_dist_q} : {1'b1, {DB{1'b0}}};
    assign take = r_scan_v && !r_done[r_jd] && (!r_have || key <= r_best_key);

    // Relaxation with saturation
    logic [DB:0]            cand_sum;
    logic [DB-1:0]          cand;
    logic                   upd;
    assign cand_sum = {1'b0, r_best_key[DB-1:0]} + (DB+1)'(r_w_q);
    assign cand     = cand_sum[DB] ? {DB{1'b1}} : cand_sum[DB-1:0];
    assign upd      = r_relax_v && !r_done[r_jd] && (r_w_q != '0)
                      && (!r_reached[r_jd] || cand < r_dist_q);

    // Weight matrix
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            wmem[r_caddr] <= '0;
        end else if (i_cmd.load && load_ok) begin
            wmem[laddr] <= w_in;
        end
        r_w_q <= wmem[raddr];
    end

    // Distance and predecessor memories
    always_ff @(posedge i_clk) begin
        if (upd) begin
            dist_mem[r_jd] <= cand;
        end else if (i_cmd.init && src_ok) begin
            dist_mem[src_idx] <= '0;
        end
        if (upd) begin
            prev_mem[r_jd] <= r_best_u;
        end
        r_dist_q <= dist_mem[r_idx];
        r_prev_q <= prev_mem[r_idx];
    end

    // Flags and search registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_done    <= '0;
            r_pv      <= '0;
            r_reached <= src_onehot;
        end else begin
            if (i_cmd.mark) r_done[r_best_u] <= 1'b1;
            if (upd) begin
                r_reached[r_jd] <= 1'b1;
                r_pv[r_jd]      <= 1'b1;
            end
        end
        if (take) begin
            r_best_key <= key;
            r_best_u   <= r_jd;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caddr   <= '0;
            r_idx     <= '0;
            r_round   <= '0;
            r_jd      <= '0;
            r_have    <= 1'b0;
            r_scan_v  <= 1'b0;
            r_relax_v <= 1'b0;
            r_emit_v  <= 1'b0;
        end else begin
            r_scan_v  <= i_cmd.scan;
            r_relax_v <= i_cmd.relax;
            r_emit_v  <= i_cmd.emit;
            r_jd      <= r_idx;
            if (i_cmd.clear_step) r_caddr <= r_caddr + 1'b1;
            if (i_cmd.init || i_cmd.mark || i_cmd.round_end) begin
                r_idx <= '0;
            end else if (i_cmd.scan || i_cmd.relax || i_cmd.emit) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.init) begin
                r_round <= '0;
            end else if (i_cmd.round_end) begin
                r_round <= r_round + 1'b1;
            end
            if (i_cmd.init || i_cmd.round_end) begin
                r_have <= 1'b0;
            end else if (take) begin
                r_have <= 1'b1;
            end
        end
    end

    assign o_status.clear_last = 32'(r_caddr) == NN - 1;
    assign o_status.idx_last   = 32'(r_idx) == VERTICES - 1;
    assign o_status.round_last = 32'(r_round) == VERTICES - 2;
    assign o_status.u_reached  = r_reached[r_best_u];

    // Result formatting
    logic [31:0] jd_ext, prev_ext;
    assign jd_ext   = 32'(r_jd);
    assign prev_ext = 32'(r_prev_q);

    assign o_result_valid    = r_emit_v;
    assign o_vertex          = jd_ext[dgsp_pkg::VTX_BITS-1:0];
    assign o_reachable       = r_reached[r_jd];
    assign o_path_length     = r_reached[r_jd] ? r_dist_q : '0;
    assign o_has_predecessor = r_pv[r_jd];
    assign o_predecessor     = r_pv[r_jd] ? prev_ext[dgsp_pkg::VTX_BITS-1:0] : '0;
    assign o_last            = r_emit_v && (jd_ext == 32'(VERTICES - 1));

endmodule : dgsp_datapath
`default_nettype wire

>>> rtl/dense_graph_shortest_paths.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dense_graph_shortest_paths
// Single-source shortest paths over a dense weight matrix (zero = no edge).
// ----------------------------------------------------------------------------
// Usage:
//  - A transaction is accepted on a rising edge with start high and busy low.
//    i_kind selects a load (write one weight at i_from_vertex/i_to_vertex,
//    ignored if out of range) or a run from i_source_vertex.
//  - A load does not raise busy, so loads can stream every cycle.
//  - A run keeps busy high while it works. Each of the VERTICES-1 rounds
//    walks every vertex once through the distance memory for the minimum
//    search, then, if the picked vertex is reached, walks its matrix row
//    once for relaxation. The read ports of the weight and distance
//    memories set this pace: one vertex per cycle.
//  - Results: VERTICES transactions, one per cycle, ascending vertex,
//    each valid for exactly one cycle with o_result_valid; o_last marks the
//    final one. The receiver cannot stall, so nothing is held back.
//  - Reset clears the controller and then sweeps the weight matrix to zero,
//    one entry a cycle, with busy high.
// ----------------------------------------------------------------------------
module dense_graph_shortest_paths #(
    parameter int VERTICES    = dgsp_pkg::VERTICES_DEF,
    parameter int WEIGHT_BITS = dgsp_pkg::WEIGHT_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          i_kind,
    input  wire logic [dgsp_pkg::VTX_BITS-1:0]  i_from_vertex,
    input  wire logic [dgsp_pkg::VTX_BITS-1:0]  i_to_vertex,
    input  wire logic [dgsp_pkg::WIN_BITS-1:0]  i_weight,
    input  wire logic [dgsp_pkg::VTX_BITS-1:0]  i_source_vertex,
    output logic                               o_result_valid,
    output logic [dgsp_pkg::VTX_BITS-1:0]       o_vertex,
    output logic [dgsp_pkg::DIST_BITS-1:0]      o_path_length,
    output logic                               o_reachable,
    output logic [dgsp_pkg::VTX_BITS-1:0]       o_predecessor,
    output logic                               o_has_predecessor,
    output logic                               o_last
);

    dgsp_pkg::t_cmd    cmd;
    dgsp_pkg::t_status status;

    // Sequencer
    dgsp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_kind   (i_kind),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // Memories, min search, relaxation, result fields
    dgsp_datapath #(
        .VERTICES    (VERTICES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_from_vertex     (i_from_vertex),
        .i_to_vertex       (i_to_vertex),
        .i_weight          (i_weight),
        .i_source_vertex   (i_source_vertex),
        .o_status          (status),
        .o_result_valid    (o_result_valid),
        .o_vertex          (o_vertex),
        .o_path_length     (o_path_length),
        .o_reachable       (o_reachable),
        .o_predecessor     (o_predecessor),
        .o_has_predecessor (o_has_predecessor),
        .o_last            (o_last)
    );

    // Results only come out during a run
    a_result_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> busy)
        else $error("result strobe while idle");

    // The final result ends the run
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |=> !busy)
        else $error("still busy after final result");

    // An accepted run keeps the block busy and silent on the next cycle
    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.init |=> (busy && !o_result_valid))
        else $error("run did not start");

endmodule : dense_graph_shortest_paths
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dense-graph shortest-path block. Loads and runs
// are queued up front, driven one transaction per handshake. The bench keeps
// its own copy of the weight matrix and solves each run itself. Every result
// transaction is checked field by field against that solution.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NV        = dgsp_pkg::VERTICES_DEF;
    localparam int VB        = dgsp_pkg::VTX_BITS;
    localparam int WB        = dgsp_pkg::WIN_BITS;
    localparam int DB        = dgsp_pkg::DIST_BITS;
    localparam int IDLE_HOLD = 200;        // cycles to watch for strays at the end

    // One queued command plus the sender's idle odds while it waits to go out
    typedef struct {
        logic                kind;
        logic [VB-1:0]       from_v;
        logic [VB-1:0]       to_v;
        logic [WB-1:0]       weight;
        logic [VB-1:0]       source;
        int unsigned         idle_pct;
    } t_graph_cmd;

    // One expected per-vertex result
    typedef struct {
        logic [VB-1:0]  vertex;
        logic [DB-1:0]  path_length;
        logic           reachable;
        logic [VB-1:0]  predecessor;
        logic           has_pred;
        logic           last;
    } t_path_result;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic                  busy;
    logic                  i_kind         = dgsp_pkg::KIND_LOAD;
    logic [VB-1:0]         i_from_vertex  = '0;
    logic [VB-1:0]         i_to_vertex    = '0;
    logic [WB-1:0]         i_weight       = '0;
    logic [VB-1:0]         i_source_vertex = '0;
    logic                  o_result_valid;
    logic [VB-1:0]         o_vertex;
    logic [DB-1:0]         o_path_length;
    logic                  o_reachable;
    logic [VB-1:0]         o_predecessor;
    logic                  o_has_predecessor;
    logic                  o_last;

    t_graph_cmd    graph_cmds[$];          // commands not yet taken by the block
    t_path_result  expected_paths[$];      // per-vertex results still owed
    logic [WB-1:0] weight_matrix[NV*NV];
    logic          xact_taken = 1'b0;      // a transaction went in at the last edge
    int unsigned   mismatch_count = 0;

    dense_graph_shortest_paths #(
        .VERTICES    (NV),
        .WEIGHT_BITS (WB)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_kind            (i_kind),
        .i_from_vertex     (i_from_vertex),
        .i_to_vertex       (i_to_vertex),
        .i_weight          (i_weight),
        .i_source_vertex   (i_source_vertex),
        .o_result_valid    (o_result_valid),
        .o_vertex          (o_vertex),
        .o_path_length     (o_path_length),
        .o_reachable       (o_reachable),
        .o_predecessor     (o_predecessor),
        .o_has_predecessor (o_has_predecessor),
        .o_last            (o_last)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic add_load(input int unsigned f, input int unsigned t,
                            input int unsigned w, input int unsigned pct);
        t_graph_cmd c;
        c.kind     = dgsp_pkg::KIND_LOAD;
        c.from_v   = f[VB-1:0];
        c.to_v     = t[VB-1:0];
        c.weight   = w[WB-1:0];
        c.source   = VB'($urandom);        // unused on a load; junk on purpose
        c.idle_pct = pct;
        graph_cmds.push_back(c);
    endtask

    task automatic add_run(input int unsigned s, input int unsigned pct);
        t_graph_cmd c;
        c.kind     = dgsp_pkg::KIND_RUN;
        c.from_v   = VB'($urandom);        // load fields are don't-care on a run
        c.to_v     = VB'($urandom);
        c.weight   = WB'($urandom);
        c.source   = s[VB-1:0];
        c.idle_pct = pct;
        graph_cmds.push_back(c);
    endtask

    // Dijkstra over the bench's copy of the matrix. Picks the lowest-distance
    // unvisited vertex, highest index on ties, unreached ones last. Pushes one
    // expected result per vertex in ascending order.
    task automatic solve_from_source(input logic [VB-1:0] src);
        logic [DB-1:0]        path_dist[NV];
        logic [VB-1:0]        pred[NV];
        logic                 visited[NV];
        logic                 reached[NV];
        logic                 pred_ok[NV];
        logic [DB:0]          key;
        logic [DB:0]          best_key;
        logic [DB:0]          cand;
        logic [WB-1:0]        w;
        bit                   have;
        int                   u;
        t_path_result         r;
        for (int j = 0; j < NV; j++) begin
            path_dist[j] = '0;
            pred[j]      = '0;
            visited[j]   = 1'b0;
            reached[j]   = 1'b0;
            pred_ok[j]   = 1'b0;
        end
        // source can't be out of range with 3-bit fields and eight vertices
        reached[src] = 1'b1;
        for (int round = 0; round < NV - 1; round++) begin
            have     = 1'b0;
            u        = 0;
            best_key = '0;
            for (int i = 0; i < NV; i++) begin
                if (!visited[i]) begin
                    key = reached[i] ? {1'b0, path_dist[i]} : {1'b1, {DB{1'b0}}};
                    if (!have || key <= best_key) begin
                        best_key = key;
                        u        = i;
                        have     = 1'b1;
                    end
                end
            end
            visited[u] = 1'b1;
            // an unreached pick relaxes nothing
            if (reached[u]) begin
                for (int j = 0; j < NV; j++) begin
                    w = weight_matrix[u*NV + j];
                    if (!visited[j] && w != '0) begin
                        cand = path_dist[u] + w;
                        if (cand[DB])
                            cand = {1'b0, {DB{1'b1}}};   // saturate
                        if (!reached[j] || cand[DB-1:0] < path_dist[j]) begin
                            path_dist[j] = cand[DB-1:0];
                            reached[j]   = 1'b1;
                            pred[j]      = u[VB-1:0];
                            pred_ok[j]   = 1'b1;
                        end
                    end
                end
            end
        end
        for (int v = 0; v < NV; v++) begin
            r.vertex      = v[VB-1:0];
            r.path_length = reached[v] ? path_dist[v] : '0;
            r.reachable   = reached[v];
            r.predecessor = pred_ok[v] ? pred[v] : '0;
            r.has_pred    = pred_ok[v];
            r.last        = (v == NV - 1);
            expected_paths.push_back(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: works on the falling edge. A presented command is held until
    // the block takes it; otherwise the sender may idle instead, driving
    // junk on the fields with start low.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || xact_taken) begin
            if (graph_cmds.size() == 0 || $urandom_range(99) < graph_cmds[0].idle_pct) begin
                start           <= 1'b0;
                i_kind          <= 1'($urandom);
                i_from_vertex   <= VB'($urandom);
                i_to_vertex     <= VB'($urandom);
                i_weight        <= WB'($urandom);
                i_source_vertex <= VB'($urandom);
            end else begin
                start           <= 1'b1;
                i_kind          <= graph_cmds[0].kind;
                i_from_vertex   <= graph_cmds[0].from_v;
                i_to_vertex     <= graph_cmds[0].to_v;
                i_weight        <= graph_cmds[0].weight;
                i_source_vertex <= graph_cmds[0].source;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: works on the rising edge. Takes accepted transactions into the
    // predictor and checks every result strobe against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_path_result want;
        xact_taken <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (start && !busy) begin
                if (i_kind == dgsp_pkg::KIND_LOAD)
                    weight_matrix[i_from_vertex*NV + i_to_vertex] = i_weight;
                else
                    solve_from_source(i_source_vertex);
                void'(graph_cmds.pop_front());
            end
            if ($isunknown(o_result_valid) || $isunknown(busy))
                report_mismatch("handshake signal is unknown");
            if (o_result_valid) begin
                if (expected_paths.size() == 0) begin
                    report_mismatch($sformatf("unexpected result for vertex %0d", o_vertex));
                end else begin
                    want = expected_paths.pop_front();
                    if (o_vertex !== want.vertex)
                        report_mismatch($sformatf("vertex: got %0d expected %0d",
                                                  o_vertex, want.vertex));
                    if (o_path_length !== want.path_length)
                        report_mismatch($sformatf("vertex %0d path_length: got %0d expected %0d",
                                                  want.vertex, o_path_length, want.path_length));
                    if (o_reachable !== want.reachable)
                        report_mismatch($sformatf("vertex %0d reachable: got %0b expected %0b",
                                                  want.vertex, o_reachable, want.reachable));
                    if (o_predecessor !== want.predecessor)
                        report_mismatch($sformatf("vertex %0d predecessor: got %0d expected %0d",
                                                  want.vertex, o_predecessor, want.predecessor));
                    if (o_has_predecessor !== want.has_pred)
                        report_mismatch($sformatf("vertex %0d has_predecessor: got %0b expected %0b",
                                                  want.vertex, o_has_predecessor, want.has_pred));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("vertex %0d last: got %0b expected %0b",
                                                  want.vertex, o_last, want.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------------
    initial begin
        int unsigned pct;
        int unsigned w;
        for (int i = 0; i < NV*NV; i++)
            weight_matrix[i] = '0;

        // Directed: empty graph first, every vertex but the source unreached
        add_run(0, 10);
        // field extremes, both directions between the end vertices
        add_load(0, 7, 16'hFFFF, 10);
        add_load(7, 0, 1, 10);
        // equal-length diamond 0->{1,2}->3: vertex 2 is picked first on the
        // tie, so it becomes 3's predecessor
        add_load(0, 1, 5, 10);
        add_load(0, 2, 5, 10);
        add_load(1, 3, 5, 10);
        add_load(2, 3, 5, 10);
        add_load(3, 3, 9, 10);       // self loop, never relaxes
        add_run(0, 10);
        add_run(7, 10);
        add_run(3, 10);              // only the self loop leaves 3
        add_load(7, 0, 0, 10);       // remove an edge again
        add_run(7, 10);
        // chain of heaviest edges for the largest reachable distances
        add_load(3, 4, 16'hFFFF, 10);
        add_load(4, 5, 16'hFFFF, 10);
        add_load(5, 6, 16'hFFFF, 10);
        add_load(6, 7, 16'hFFFF, 10);
        add_run(0, 10);
        add_run(5, 10);
        add_load(7, 7, 16'hFFFF, 10);
        add_run(6, 10);
        // distance saturation and out-of-range loads or sources can't occur
        // at eight vertices with 16-bit weights and 3-bit vertex fields

        // Random: sender idles lightly, then heavily, then not at all.
        // Small weights dominate so ties and rival paths are common.
        for (int n = 0; n < 100; n++) begin
            pct = (n < 33) ? 10 : (n < 67) ? 61 : 0;
            if ($urandom_range(99) < 20) begin
                add_run($urandom_range(NV-1), pct);
            end else begin
                case ($urandom_range(9))
                    0, 1, 2: w = 0;
                    3, 4:    w = $urandom_range(16'hFFFF);
                    default: w = $urandom_range(15, 1);
                endcase
                add_load($urandom_range(NV-1), $urandom_range(NV-1), w, pct);
            end
        end
        add_run($urandom_range(NV-1), 0);

        // synchronous reset, released on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (graph_cmds.size() != 0 || expected_paths.size() != 0)
            @(posedge i_clk);
        // watch a while longer for stray results
        repeat (IDLE_HOLD) @(posedge i_clk);

        if (expected_paths.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_paths.size()));
        if (mismatch_count == 0)
            $display("dense_graph_shortest_paths test passed");
        else
            $display("dense_graph_shortest_paths test failed");
        $finish;
    end

    // Watchdog, ends the test if it hangs
    initial begin
        #400000;
        $display("dense_graph_shortest_paths test failed");
        $finish;
    end

endmodule

>>> files.f
rtl/dgsp_pkg.sv
rtl/dgsp_ctrl.sv
rtl/dgsp_datapath.sv
rtl/dense_graph_shortest_paths.sv
bench/tb_top.sv
